[rtl/lcdr_pkg.sv]
package lcdr_pkg;

	// Field widths
	localparam int READ_W    = 24;
	localparam int VALUE_W   = 26;
	localparam int HALF_W    = 16;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;
	localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_READING_MASK = 2'd1;

	// Register reset values
	localparam logic [HALF_W-1:0] HALF_RESET = 16'd1;
	localparam logic [READ_W-1:0] MASK_RESET = 24'h000FFF;

	// Extra clock pulses that select the next channel and gain
	localparam logic [2:0] PULSES_AFTER_FIRST  = 3'd2;
	localparam logic [2:0] PULSES_AFTER_SECOND = 3'd3;

	typedef enum logic [2:0] {
		MODE_IDLE  = 3'b001,
		MODE_DATA  = 3'b010,
		MODE_EXTRA = 3'b100
	} lcdr_mode_t;

	typedef struct packed {
		logic [HALF_W-1:0] half_period_ticks;
		logic [READ_W-1:0] reading_mask;
	} lcdr_cfg_t;

	typedef struct packed {
		logic               sck_level;
		logic               thrust_valid;
		logic [VALUE_W-1:0] thrust_value;
	} lcdr_result_t;

endpackage

[rtl/lcdr_in_if.sv]
interface lcdr_in_if;
	logic valid;
	logic ready;
	logic dout_level;

	modport source (output valid, output dout_level, input ready);
	modport sink (input valid, input dout_level, output ready);
endinterface

[rtl/lcdr_out_if.sv]
interface lcdr_out_if import lcdr_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               sck_level;
	logic               thrust_valid;
	logic [VALUE_W-1:0] thrust_value;

	modport source (output valid, output sck_level, output thrust_valid, output thrust_value,
		input ready);
	modport sink (input valid, input sck_level, input thrust_valid, input thrust_value,
		output ready);
endinterface

[rtl/lcdr_cfg_if.sv]
interface lcdr_cfg_if import lcdr_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/load_cell_dual_channel_reader.sv]
// Two-wire load-cell converter reader. Each input word is one tick carrying the
// sampled data pin; each tick yields one output word with the clock pin level to
// drive, and on the tick a pair of conversions completes, thrust_valid with
// first reading plus twice the second (both masked by reading_mask). The block
// takes one word per clock cycle: the tick is handled by the state registers and
// one level of logic, and the result sits in an output register that is refilled
// in the same cycle it is taken, so throughput is one word per cycle whenever
// the output side is ready. Each accepted tick's word is valid in the following cycle.
module load_cell_dual_channel_reader import lcdr_pkg::*; #(
	parameter int DATA_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	lcdr_cfg_if.sink    cfg,
	lcdr_in_if.sink     sample_in,
	lcdr_out_if.source  result_out
);

	lcdr_cfg_t    cfg_regs;
	lcdr_result_t result;
	lcdr_result_t out_q;
	logic         out_valid_q;
	logic         step;

	lcdr_cfg_regs u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.cfg_regs (cfg_regs)
	);

	assign sample_in.ready = !out_valid_q || result_out.ready;
	assign step            = sample_in.valid && sample_in.ready;

	lcdr_core #(
		.DATA_BITS (DATA_BITS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.dout_level (sample_in.dout_level),
		.cfg_regs   (cfg_regs),
		.result     (result)
	);

	// Hold the result word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_q <= result;
		end
	end

	assign result_out.valid        = out_valid_q;
	assign result_out.sck_level    = out_q.sck_level;
	assign result_out.thrust_valid = out_q.thrust_valid;
	assign result_out.thrust_value = out_q.thrust_value;

endmodule

[rtl/lcdr_cfg_regs.sv]
module lcdr_cfg_regs import lcdr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	lcdr_cfg_if.sink  cfg,
	output lcdr_cfg_t cfg_regs
);

	logic [HALF_W-1:0] half_q;
	logic [READ_W-1:0] mask_q;

	assign cfg.ready = 1'b1;

	// Write the addressed register, drop writes to unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q <= HALF_RESET;
			mask_q <= MASK_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_HALF_PERIOD:  half_q <= cfg.data[HALF_W-1:0];
				CFG_READING_MASK: mask_q <= cfg.data[READ_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg_regs.half_period_ticks = half_q;
	assign cfg_regs.reading_mask      = mask_q;

endmodule

[rtl/lcdr_core.sv]
module lcdr_core import lcdr_pkg::*; #(
	parameter int DATA_BITS = 24
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         step,
	input  logic         dout_level,
	input  lcdr_cfg_t    cfg_regs,
	output lcdr_result_t result
);

	localparam int PC_W  = $clog2(DATA_BITS + 1);
	localparam int EXT_W = (DATA_BITS > READ_W) ? DATA_BITS : READ_W;

	lcdr_mode_t           mode_q, mode_n;
	logic [PC_W-1:0]      pulse_q, pulse_n, pulse_inc;
	logic [HALF_W-1:0]    phase_q, phase_n, phase_inc, half_eff;
	logic [DATA_BITS-1:0] shift_q, shift_n;
	logic [READ_W-1:0]    first_q, first_n, reading;
	logic                 second_q, second_n;
	logic                 clk_high_q, clk_high_n;
	logic [EXT_W-1:0]     shift_ext;
	logic [PC_W-1:0]      extra_limit;

	assign half_eff    = (cfg_regs.half_period_ticks == '0) ? HALF_W'(1)
		: cfg_regs.half_period_ticks;
	assign shift_ext   = EXT_W'(shift_q);
	assign reading     = shift_ext[READ_W-1:0] & cfg_regs.reading_mask;
	assign phase_inc   = phase_q + HALF_W'(1);
	assign pulse_inc   = pulse_q + PC_W'(1);
	assign extra_limit = second_q ? PC_W'(PULSES_AFTER_SECOND) : PC_W'(PULSES_AFTER_FIRST);

	// Next state and result for this tick
	always_comb begin
		mode_n     = mode_q;
		pulse_n    = pulse_q;
		phase_n    = phase_q;
		shift_n    = shift_q;
		first_n    = first_q;
		second_n   = second_q;
		clk_high_n = clk_high_q;
		result     = '0;
		case (mode_q)
			MODE_IDLE: begin
				// Converter ready: start the clock on the next tick
				if (!dout_level) begin
					mode_n     = MODE_DATA;
					clk_high_n = 1'b1;
					phase_n    = '0;
					pulse_n    = '0;
					shift_n    = '0;
				end
			end
			MODE_DATA, MODE_EXTRA: begin
				result.sck_level = clk_high_q;
				phase_n = phase_inc;
				if (phase_inc >= half_eff) begin
					phase_n = '0;
					if (clk_high_q) begin
						// End of high phase: sample the data pin in data mode
						if (mode_q == MODE_DATA) begin
							shift_n = {shift_q[DATA_BITS-2:0], dout_level};
						end
						clk_high_n = 1'b0;
					end else begin
						pulse_n = pulse_inc;
						if (mode_q == MODE_DATA && pulse_inc >= PC_W'(DATA_BITS)) begin
							mode_n     = MODE_EXTRA;
							pulse_n    = '0;
							clk_high_n = 1'b1;
						end else if (mode_q == MODE_EXTRA && pulse_inc >= extra_limit) begin
							// Conversion done: store first reading or combine
							mode_n  = MODE_IDLE;
							pulse_n = '0;
							if (!second_q) begin
								first_n  = reading;
								second_n = 1'b1;
							end else begin
								result.thrust_valid = 1'b1;
								result.thrust_value = VALUE_W'(first_q)
									+ (VALUE_W'(reading) << 1);
								second_n = 1'b0;
							end
						end else begin
							clk_high_n = 1'b1;
						end
					end
				end
			end
			default: begin
				mode_n = MODE_IDLE;
			end
		endcase
	end

	// Advance state on each accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_IDLE;
			pulse_q    <= '0;
			phase_q    <= '0;
			shift_q    <= '0;
			first_q    <= '0;
			second_q   <= 1'b0;
			clk_high_q <= 1'b0;
		end else if (step) begin
			mode_q     <= mode_n;
			pulse_q    <= pulse_n;
			phase_q    <= phase_n;
			shift_q    <= shift_n;
			first_q    <= first_n;
			second_q   <= second_n;
			clk_high_q <= clk_high_n;
		end
	end

endmodule

[rtl/lcdr_checker.sv]
module lcdr_checker import lcdr_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic               sck_level,
	input logic               thrust_valid,
	input logic [VALUE_W-1:0] thrust_value
);

	// A word with no combined result carries zero
	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !thrust_valid) |-> (thrust_value == '0))
		else $error("thrust_value nonzero without thrust_valid");

	// Results complete on a clock-low tick
	a_result_low: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && thrust_valid) |-> !sck_level)
		else $error("combined result on a clock-high tick");

	// An empty output register never blocks the input
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	// An accepted tick shows up as an output word next cycle
	a_accept_out: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> out_valid)
		else $error("accepted word produced no output");

	// A stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(thrust_value)
			&& $stable(thrust_valid) && $stable(sck_level)))
		else $error("output word changed while stalled");

endmodule

bind load_cell_dual_channel_reader lcdr_checker u_lcdr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (sample_in.valid),
	.in_ready     (sample_in.ready),
	.out_valid    (result_out.valid),
	.out_ready    (result_out.ready),
	.sck_level    (result_out.sck_level),
	.thrust_valid (result_out.thrust_valid),
	.thrust_value (result_out.thrust_value)
);

[dv/lcdr_pair_monitor.sv]
`timescale 1ns / 100ps
module lcdr_pair_monitor import lcdr_pkg::*; #(
	parameter int READ_BITS = 24
) (
	input  logic clk,
	input  logic arst_n,
	lcdr_cfg_if  cfg_bus,
	lcdr_in_if   tick_bus,
	lcdr_out_if  word_bus,
	output int   fail_count,
	output int   owed_count,
	output int   words_checked,
	output int   sums_seen
);

	// Shadow copy of the reader: registers and conversion state
	lcdr_cfg_t         rd_cfg;
	lcdr_mode_t        rd_mode;
	logic [5:0]        rd_pulses;
	logic [HALF_W-1:0] rd_phase;
	logic [31:0]       rd_shift;
	logic [READ_W-1:0] rd_first;
	logic              rd_want_second;
	logic              rd_sck_high;

	// Output words still owed by the block, oldest first
	lcdr_result_t      owed_words[$];

	// Advance the reader by one tick and return the word it drives for that tick
	function automatic lcdr_result_t reader_tick(input logic level);
		lcdr_result_t      w;
		logic [HALF_W-1:0] half;
		logic [READ_W-1:0] reading;
		logic [2:0]        extra;
		w = '0;
		half = (rd_cfg.half_period_ticks == '0) ? HALF_W'(1) : rd_cfg.half_period_ticks;
		extra = rd_want_second ? PULSES_AFTER_SECOND : PULSES_AFTER_FIRST;
		if (rd_mode == MODE_IDLE) begin
			// Data pin low means the converter is ready: clock stays low this tick
			if (!level) begin
				rd_mode = MODE_DATA;
				rd_sck_high = 1'b1;
				rd_phase = '0;
				rd_pulses = '0;
				rd_shift = '0;
			end
		end else begin
			w.sck_level = rd_sck_high;
			rd_phase = rd_phase + 1'b1;
			if (rd_phase >= half) begin
				rd_phase = '0;
				if (rd_sck_high) begin
					// Sample the data pin at the end of the high phase in data mode
					if (rd_mode == MODE_DATA) begin
						rd_shift = {rd_shift[30:0], level};
					end
					rd_sck_high = 1'b0;
				end else begin
					rd_pulses = rd_pulses + 1'b1;
					if (rd_mode == MODE_DATA && rd_pulses >= READ_BITS) begin
						rd_mode = MODE_EXTRA;
						rd_pulses = '0;
						rd_sck_high = 1'b1;
					end else if (rd_mode == MODE_EXTRA && rd_pulses >= extra) begin
						// Reading done: store the first, combine on the second
						reading = rd_shift[READ_W-1:0] & rd_cfg.reading_mask;
						rd_mode = MODE_IDLE;
						rd_pulses = '0;
						if (!rd_want_second) begin
							rd_first = reading;
							rd_want_second = 1'b1;
						end else begin
							w.thrust_valid = 1'b1;
							w.thrust_value = {2'b00, rd_first} + {1'b0, reading, 1'b0};
							rd_want_second = 1'b0;
						end
					end else begin
						rd_sck_high = 1'b1;
					end
				end
			end
		end
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		lcdr_result_t want;
		if (!arst_n) begin
			rd_cfg.half_period_ticks = HALF_RESET;
			rd_cfg.reading_mask = MASK_RESET;
			rd_mode = MODE_IDLE;
			rd_pulses = '0;
			rd_phase = '0;
			rd_shift = '0;
			rd_first = '0;
			rd_want_second = 1'b0;
			rd_sck_high = 1'b0;
			owed_words.delete();
			fail_count = 0;
			owed_count = 0;
			words_checked = 0;
			sums_seen = 0;
		end else begin
			// Compare each output word with the oldest owed one
			if (word_bus.valid && word_bus.ready) begin
				words_checked++;
				if (owed_words.size() == 0) begin
					$error("word with nothing owed: sck %0d valid %0d value %0d",
						word_bus.sck_level, word_bus.thrust_valid, word_bus.thrust_value);
					fail_count++;
				end else begin
					want = owed_words.pop_front();
					if (word_bus.sck_level !== want.sck_level) begin
						$error("sck_level: expected %0d, got %0d", want.sck_level,
							word_bus.sck_level);
						fail_count++;
					end
					if (word_bus.thrust_valid !== want.thrust_valid) begin
						$error("thrust_valid: expected %0d, got %0d", want.thrust_valid,
							word_bus.thrust_valid);
						fail_count++;
					end
					if (word_bus.thrust_value !== want.thrust_value) begin
						$error("thrust_value: expected %0d, got %0d", want.thrust_value,
							word_bus.thrust_value);
						fail_count++;
					end
					if (want.thrust_valid) begin
						sums_seen++;
					end
				end
			end
			// Apply register writes; unknown indexes drop silently
			if (cfg_bus.valid && cfg_bus.ready) begin
				case (cfg_bus.index)
					CFG_HALF_PERIOD: begin
						rd_cfg.half_period_ticks = cfg_bus.data[HALF_W-1:0];
					end
					CFG_READING_MASK: begin
						rd_cfg.reading_mask = cfg_bus.data[READ_W-1:0];
					end
					default: begin
					end
				endcase
			end
			// Every accepted tick owes exactly one output word
			if (tick_bus.valid && tick_bus.ready) begin
				owed_words.push_back(reader_tick(tick_bus.dout_level));
			end
			owed_count = owed_words.size();
		end
	end

endmodule

[dv/load_cell_dual_channel_reader_tb.sv]
`timescale 1ns / 100ps
module load_cell_dual_channel_reader_tb;
	import lcdr_pkg::*;

	localparam int READ_BITS     = 24;
	localparam int QUIET_LIMIT   = 1000;
	localparam int SETTLE_CYCLES = 4;
	localparam int LONG_HOLD     = 80;
	localparam int MIN_TICKS     = 650;

	// Indexes past the register file, written to check they are dropped
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

	logic clk;
	logic arst_n;

	lcdr_cfg_if cfg_ch ();
	lcdr_in_if  tick_ch ();
	lcdr_out_if word_ch ();

	int fail_count;
	int owed_count;
	int words_checked;
	int sums_seen;
	int ticks_sent;
	int writes_done;
	int quiet_cycles;

	logic [HALF_W-1:0] cur_half;
	bit second_next;
	bit tx_steady;
	bit rx_steady;
	bit rx_hold_req;

	load_cell_dual_channel_reader #(.DATA_BITS(READ_BITS)) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_ch),
		.sample_in  (tick_ch),
		.result_out (word_ch)
	);

	lcdr_pair_monitor #(.READ_BITS(READ_BITS)) pair_mon (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_bus       (cfg_ch),
		.tick_bus      (tick_ch),
		.word_bus      (word_ch),
		.fail_count    (fail_count),
		.owed_count    (owed_count),
		.words_checked (words_checked),
		.sums_seen     (sums_seen)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Offer one tick word after a random gap (none when tx_steady) and hold it until taken
	task automatic send_tick(input logic level);
		int gap;
		gap = tx_steady ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			tick_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		tick_ch.valid <= 1'b1;
		tick_ch.dout_level <= level;
		@(posedge clk);
		while (!tick_ch.ready) @(posedge clk);
		@(negedge clk);
		ticks_sent++;
	endtask

	// Stop offering ticks and wait until every owed word is out
	task automatic settle();
		tick_ch.valid <= 1'b0;
		while (owed_count != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		@(negedge clk);
		if (idx == CFG_HALF_PERIOD) begin
			cur_half = val[HALF_W-1:0];
		end
		writes_done++;
	endtask

	// Play a converter: ready, then the word MSB first, then high through the extra pulses
	task automatic run_conversion(input logic [READ_BITS-1:0] word, input bit noisy);
		int   span;
		int   total;
		int   lead;
		logic lvl;
		span = 2 * ((cur_half == '0) ? 1 : int'(cur_half));
		total = span * (READ_BITS +
			(second_next ? int'(PULSES_AFTER_SECOND) : int'(PULSES_AFTER_FIRST)));
		lead = $urandom_range(0, 4);
		repeat (lead) send_tick(1'b1);
		send_tick(1'b0);
		for (int n = 0; n < total; n++) begin
			lvl = (n < span * READ_BITS) ? word[READ_BITS - 1 - n / span] : 1'b1;
			if (noisy && $urandom_range(0, 7) == 0) begin
				lvl = ~lvl;
			end
			send_tick(lvl);
		end
		second_next = ~second_next;
	endtask

	// Drain output words with random stalls unless rx_steady, and one long hold when asked
	initial begin : result_sink
		int gap;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (rx_hold_req) begin
				gap = LONG_HOLD;
				rx_hold_req = 1'b0;
			end else begin
				gap = rx_steady ? 0 : $urandom_range(0, 12);
			end
			if (gap > 0) begin
				word_ch.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			word_ch.ready <= 1'b1;
			@(posedge clk);
			while (!word_ch.valid) @(posedge clk);
			@(negedge clk);
		end
	end

	// Abort when no channel moves a word for too long
	initial begin : watchdog
		quiet_cycles = 0;
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
			if ((tick_ch.valid && tick_ch.ready) || (word_ch.valid && word_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
		end
		$display("CHECK FAILED");
		$finish;
	end

	initial begin : stimulus
		logic [READ_BITS-1:0] word;
		int                   pick;
		arst_n = 1'b0;
		tick_ch.valid = 1'b0;
		tick_ch.dout_level = 1'b1;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_HALF_PERIOD;
		cfg_ch.data = '0;
		word_ch.ready = 1'b0;
		ticks_sent = 0;
		writes_done = 0;
		cur_half = HALF_RESET;
		second_next = 1'b0;
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		rx_hold_req = 1'b0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: idle with the pin high, then one pair under the narrow mask
		repeat (3) send_tick(1'b1);
		run_conversion(24'hABCDEF, 1'b0);
		run_conversion(24'hFFFFFF, 1'b0);

		// Full mask, all-ones pair gives the largest sum; hold the output meanwhile
		settle();
		write_reg(CFG_READING_MASK, 24'hFFFFFF);
		rx_hold_req = 1'b1;
		run_conversion(24'hFFFFFF, 1'b0);
		run_conversion(24'hFFFFFF, 1'b0);

		// Empty mask: a valid sum of zero
		settle();
		write_reg(CFG_READING_MASK, 24'h000000);
		run_conversion(24'h123456, 1'b0);
		run_conversion(24'h654321, 1'b0);

		// Unknown indexes are dropped; zero half period acts as one
		settle();
		write_reg(CFG_SPARE_A, 24'hFFFFFF);
		write_reg(CFG_SPARE_B, 24'h000000);
		write_reg(CFG_READING_MASK, 24'hFFFFFF);
		write_reg(CFG_HALF_PERIOD, 24'h000000);
		run_conversion(24'h000000, 1'b0);
		run_conversion(24'h800001, 1'b0);

		// Longest half period, then shorten it in the middle of the high phase
		settle();
		write_reg(CFG_HALF_PERIOD, 24'h00FFFF);
		send_tick(1'b0);
		repeat (30) send_tick(1'($urandom_range(0, 1)));
		settle();
		write_reg(CFG_HALF_PERIOD, 24'h000001);
		repeat (2 * (READ_BITS + int'(PULSES_AFTER_SECOND)) + 4) send_tick(1'b1);
		second_next = ~second_next;

		// Two-tick phases with a patterned mask
		settle();
		write_reg(CFG_HALF_PERIOD, 24'h000002);
		write_reg(CFG_READING_MASK, 24'hF0F0F0);
		run_conversion(24'($urandom), 1'b0);
		run_conversion(24'($urandom), 1'b0);

		// Random phases: new settings, well-formed conversions, some noise
		while (ticks_sent < MIN_TICKS) begin
			settle();
			tx_steady = ($urandom_range(0, 3) == 0);
			rx_steady = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 9) < 7) begin
				pick = $urandom_range(0, 9);
				if (pick == 0) begin
					write_reg(CFG_HALF_PERIOD, 24'd0);
				end else if (pick < 6) begin
					write_reg(CFG_HALF_PERIOD, 24'd1);
				end else if (pick < 9) begin
					write_reg(CFG_HALF_PERIOD, 24'd2);
				end else begin
					write_reg(CFG_HALF_PERIOD, 24'd3);
				end
			end
			if ($urandom_range(0, 9) < 7) begin
				case ($urandom_range(0, 5))
					0: write_reg(CFG_READING_MASK, 24'h000000);
					1: write_reg(CFG_READING_MASK, MASK_RESET);
					2, 3: write_reg(CFG_READING_MASK, 24'($urandom));
					default: write_reg(CFG_READING_MASK, 24'hFFFFFF);
				endcase
			end
			if ($urandom_range(0, 9) == 0) begin
				write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, 24'($urandom));
			end
			if ($urandom_range(0, 5) == 0) begin
				rx_hold_req = 1'b1;
			end
			repeat ($urandom_range(2, 4)) begin
				case ($urandom_range(0, 9))
					0: word = '0;
					1: word = '1;
					default: word = READ_BITS'($urandom);
				endcase
				run_conversion(word, $urandom_range(0, 3) == 0);
			end
			// Broken sequence: random pin levels out of step with the converter
			if ($urandom_range(0, 4) == 0) begin
				repeat ($urandom_range(1, 20)) send_tick(1'($urandom_range(0, 1)));
			end
		end

		settle();
		$display("Sent %0d ticks with %0d register writes; %0d output words checked.",
			ticks_sent, writes_done, words_checked);
		$display("%0d thrust sums seen across masks from empty to full",
			sums_seen);
		$display("and half periods from 0 to 65535.");
		if (fail_count == 0 && owed_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
